// ===== hw/rtl/mi4_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// shared types, constants and cofactor step plan for the 4x4 matrix inverse
package mi4_pkg;

    // width of one multiplier digit taken from the wide operand
    localparam int CHUNK_BITS = 16;

    localparam logic [3:0] LAST_COF_STEP = 4'd8;
    localparam logic [3:0] LAST_DET_STEP = 4'd3;
    localparam logic [3:0] LAST_COF_IDX  = 4'd15;
    localparam logic [1:0] LAST_POS      = 2'd3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FETCH_A,
        ST_FETCH_B,
        ST_MUL,
        ST_ROW,
        ST_DIV_GO,
        ST_DIV,
        ST_EMIT
    } state_t;

    typedef enum logic {
        PH_COF,
        PH_DET
    } phase_t;

    // kind of wide operand, sets the number of digits
    typedef enum logic [1:0] {
        OP_ELEM,
        OP_MINOR,
        OP_COF
    } opnd_t;

    typedef struct packed {
        logic  start;
        opnd_t kind;
    } mul_ctrl_t;

    // one multiply-accumulate of a cofactor: positions among the kept rows/columns
    typedef struct packed {
        logic [1:0] a_rpos;
        logic [1:0] a_cpos;
        logic       b_minor;
        logic [1:0] b_rpos;
        logic [1:0] b_cpos;
        logic [1:0] m_idx;
        logic       neg;
        logic       clear;
        logic       last;
    } step_t;

    // index of the n-th kept row or column when one is removed
    function automatic logic [1:0] pick(input logic [1:0] pos, input logic [1:0] skip);
        logic [1:0] r;
        r = (pos >= skip) ? pos + 2'd1 : pos;
        return r;
    endfunction

    // three 2x2 minors, then the expansion along the first kept row
    function automatic step_t cof_step(input logic [3:0] s);
        step_t st;
        st = '0;
        unique case (s)
            4'd0: st = step_t'{2'd1, 2'd1, 1'b0, 2'd2, 2'd2, 2'd0, 1'b0, 1'b1, 1'b0};
            4'd1: st = step_t'{2'd1, 2'd2, 1'b0, 2'd2, 2'd1, 2'd0, 1'b1, 1'b0, 1'b1};
            4'd2: st = step_t'{2'd1, 2'd0, 1'b0, 2'd2, 2'd2, 2'd1, 1'b0, 1'b1, 1'b0};
            4'd3: st = step_t'{2'd1, 2'd2, 1'b0, 2'd2, 2'd0, 2'd1, 1'b1, 1'b0, 1'b1};
            4'd4: st = step_t'{2'd1, 2'd0, 1'b0, 2'd2, 2'd1, 2'd2, 1'b0, 1'b1, 1'b0};
            4'd5: st = step_t'{2'd1, 2'd1, 1'b0, 2'd2, 2'd0, 2'd2, 1'b1, 1'b0, 1'b1};
            4'd6: st = step_t'{2'd0, 2'd0, 1'b1, 2'd0, 2'd0, 2'd0, 1'b0, 1'b1, 1'b0};
            4'd7: st = step_t'{2'd0, 2'd1, 1'b1, 2'd0, 2'd0, 2'd1, 1'b1, 1'b0, 1'b0};
            4'd8: st = step_t'{2'd0, 2'd2, 1'b1, 2'd0, 2'd0, 2'd2, 1'b0, 1'b0, 1'b1};
            default: st = '0;
        endcase
        return st;
    endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/mi4_mul.sv =====
`timescale 1ns / 1ps
`default_nettype none
// shared multiplier: element times wide operand, one 16-bit digit per cycle
module mi4_mul #(
    parameter int DW = 32,
    parameter int MW = 66,
    parameter int BW = 112,
    parameter int AW = 134
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  mi4_pkg::mul_ctrl_t     ctrl,
    input  logic signed [DW-1:0]   a,
    input  logic signed [BW-1:0]   b,
    output logic signed [AW-1:0]   p,
    output logic                   done
);
    import mi4_pkg::*;

    localparam int NCH_C = BW / CHUNK_BITS;
    localparam int NCH_M = (MW + CHUNK_BITS - 1) / CHUNK_BITS;
    localparam int NCH_E = (DW + CHUNK_BITS - 1) / CHUNK_BITS;
    localparam int KW    = $clog2(NCH_C);

    logic signed [DW-1:0]         a_reg;
    logic        [BW-1:0]         b_reg;
    logic        [KW-1:0]         k_reg;
    logic        [KW-1:0]         k_top;
    logic signed [AW-1:0]         p_reg;
    logic signed [AW-1:0]         p_next;
    logic                         run_reg;
    logic                         first_reg;
    logic                         done_reg;
    logic        [CHUNK_BITS-1:0] chunk;
    logic signed [CHUNK_BITS:0]   digit;
    logic signed [DW+CHUNK_BITS:0] prod;

    // top digit index for the operand kind
    always_comb
    begin
        unique case (ctrl.kind)
            OP_ELEM:  k_top = KW'(NCH_E - 1);
            OP_MINOR: k_top = KW'(NCH_M - 1);
            default:  k_top = KW'(NCH_C - 1);
        endcase
    end

    // digits from the top down; only the top one carries the sign
    always_comb
    begin
        chunk  = b_reg[k_reg*CHUNK_BITS +: CHUNK_BITS];
        digit  = $signed({first_reg & chunk[CHUNK_BITS-1], chunk});
        prod   = a_reg * digit;
        p_next = (first_reg ? AW'(0) : (p_reg <<< CHUNK_BITS)) + AW'(prod);
    end

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg   <= 1'b0;
            first_reg <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= run_reg && (k_reg == '0);
            if (ctrl.start)
            begin
                run_reg   <= 1'b1;
                first_reg <= 1'b1;
            end
            else if (run_reg)
            begin
                first_reg <= 1'b0;
                if (k_reg == '0)
                begin
                    run_reg <= 1'b0;
                end
            end
        end
    end

    // operands and partial product
    always_ff @(posedge clk)
    begin
        if (ctrl.start)
        begin
            a_reg <= a;
            b_reg <= b;
            k_reg <= k_top;
        end
        else if (run_reg)
        begin
            p_reg <= p_next;
            if (k_reg != '0)
            begin
                k_reg <= k_reg - KW'(1);
            end
        end
    end

    assign p    = p_reg;
    assign done = done_reg;

endmodule
`default_nettype wire

// ===== hw/rtl/mi4_div.sv =====
`timescale 1ns / 1ps
`default_nettype none
// restoring divider, one quotient bit per cycle, quotient limited to DW+1 bits
module mi4_div #(
    parameter int DW  = 32,
    parameter int NW  = 132,
    parameter int DTW = 134
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [NW-1:0] num,
    input  logic [DTW-1:0] den,
    output logic [DW:0]   q,
    output logic          done
);
    localparam int SW   = DTW + DW;
    localparam int QW   = (NW > SW) ? NW : SW;
    localparam int CNTW = $clog2(DW + 1);

    logic [QW-1:0]   r_reg;
    logic [QW-1:0]   d_reg;
    logic [DW:0]     q_reg;
    logic [CNTW-1:0] cnt_reg;
    logic            run_reg;
    logic            done_reg;
    logic            ge;

    assign ge = (r_reg >= d_reg);

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= run_reg && (cnt_reg == '0);
            if (start)
            begin
                run_reg <= 1'b1;
            end
            else if (run_reg && (cnt_reg == '0))
            begin
                run_reg <= 1'b0;
            end
        end
    end

    // compare and subtract against the divisor shifted to the current bit
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            r_reg   <= QW'(num);
            d_reg   <= QW'({den, {DW{1'b0}}});
            q_reg   <= '0;
            cnt_reg <= CNTW'(DW);
        end
        else if (run_reg)
        begin
            if (ge)
            begin
                r_reg <= r_reg - d_reg;
            end
            q_reg <= {q_reg[DW-1:0], ge};
            d_reg <= d_reg >> 1;
            if (cnt_reg != '0)
            begin
                cnt_reg <= cnt_reg - CNTW'(1);
            end
        end
    end

    assign q    = q_reg;
    assign done = done_reg;

endmodule
`default_nettype wire

// ===== hw/rtl/matrix_inverse_4x4.sv =====
`timescale 1ns / 1ps
`default_nettype none
// 4x4 fixed-point matrix inverse by cofactor expansion
//
// Input: one matrix row per transfer, elem0..elem3, taken at a clock edge with
// start high and busy low. Rows 0..2 are stored and busy stays low. The fourth
// row starts the inversion and raises busy.
// Output: four inverse rows, each shown for one cycle with valid high,
// row_number 0..3, last_row on the fourth; singular marks a zero determinant
// (rows are then zero), saturated marks a row with a clamped element.
// Each multiply-accumulate runs on the shared multiplier, one 16-bit digit
// of the wide operand at a time; each quotient runs on the serial divider.
// The 16 cofactors come first, then the determinant, then the 16 quotients
// with the four output rows; when singular the quotients are skipped.
// Results cannot be held off; busy stays high until the last row is out.
// Reset returns to the first row and clears the sequencer; stored data is
// not cleared.
module matrix_inverse_4x4 #(
    parameter int DATA_WIDTH = 32,
    parameter int FRAC_BITS  = 16
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic signed [DATA_WIDTH-1:0] elem0,
    input  logic signed [DATA_WIDTH-1:0] elem1,
    input  logic signed [DATA_WIDTH-1:0] elem2,
    input  logic signed [DATA_WIDTH-1:0] elem3,
    output logic                         valid,
    output logic signed [DATA_WIDTH-1:0] inv0,
    output logic signed [DATA_WIDTH-1:0] inv1,
    output logic signed [DATA_WIDTH-1:0] inv2,
    output logic signed [DATA_WIDTH-1:0] inv3,
    output logic [1:0]                   row_number,
    output logic                         last_row,
    output logic                         singular,
    output logic                         saturated
);
    import mi4_pkg::*;

    localparam int DW  = DATA_WIDTH;
    localparam int MW  = 2 * DW + 2;
    localparam int CFW = 3 * DW + 4;
    localparam int DTW = 4 * DW + 6;
    localparam int NW  = CFW + 2 * FRAC_BITS;
    localparam int BW  = ((CFW + CHUNK_BITS - 1) / CHUNK_BITS) * CHUNK_BITS;

    state_t state_reg, state_next;
    phase_t phase_reg;
    logic [3:0] ci_reg;
    logic [3:0] s_reg;
    logic [1:0] row_reg;
    logic [1:0] col_reg;
    logic [1:0] rows_loaded_reg;

    logic signed [DW-1:0]  mat_reg [4][4];
    logic signed [MW-1:0]  minor_reg [3];
    logic signed [CFW-1:0] cof_reg [16];
    logic signed [DW-1:0]  a_reg;
    logic signed [DTW-1:0] acc_reg;
    logic signed [DTW-1:0] det_reg;
    logic signed [DW-1:0]  inv_reg [4];
    logic                  sat_reg;
    logic                  sing_reg;

    step_t      st;
    logic [1:0] cur_i, cur_j;
    logic [1:0] a_row, a_col, b_row, b_col;
    logic       step_neg, step_clear, step_last;
    opnd_t      b_kind;
    logic signed [BW-1:0]  b_opnd;

    mul_ctrl_t             mul_ctrl;
    logic signed [DTW-1:0] mul_p;
    logic                  mul_done;
    logic signed [DTW-1:0] acc_new;

    logic                  div_start;
    logic                  div_done;
    logic [DW:0]           div_q;
    logic signed [CFW-1:0] cof_sel;
    logic [CFW-1:0]        cof_abs;
    logic [DTW-1:0]        det_abs;
    logic [NW-1:0]         div_num;
    logic                  det_zero;
    logic                  res_neg;
    logic                  res_sat;
    logic signed [DW-1:0]  res_val;

    // step decode: which elements and minor feed the multiplier
    always_comb
    begin
        cur_i = ci_reg[3:2];
        cur_j = ci_reg[1:0];
        st    = cof_step(s_reg);
        if (phase_reg == PH_COF)
        begin
            a_row      = pick(st.a_rpos, cur_i);
            a_col      = pick(st.a_cpos, cur_j);
            b_row      = pick(st.b_rpos, cur_i);
            b_col      = pick(st.b_cpos, cur_j);
            step_neg   = st.neg ^ (st.b_minor & (cur_i[0] ^ cur_j[0]));
            step_clear = st.clear;
            step_last  = st.last;
        end
        else
        begin
            a_row      = 2'd0;
            a_col      = s_reg[1:0];
            b_row      = 2'd0;
            b_col      = 2'd0;
            step_neg   = 1'b0;
            step_clear = (s_reg == 4'd0);
            step_last  = (s_reg == LAST_DET_STEP);
        end
    end

    // wide operand select
    always_comb
    begin
        if (phase_reg == PH_DET)
        begin
            b_opnd = BW'(cof_reg[{2'b00, s_reg[1:0]}]);
            b_kind = OP_COF;
        end
        else if (st.b_minor)
        begin
            b_opnd = BW'(minor_reg[st.m_idx]);
            b_kind = OP_MINOR;
        end
        else
        begin
            b_opnd = BW'(mat_reg[b_row][b_col]);
            b_kind = OP_ELEM;
        end
    end

    assign acc_new = (step_clear ? DTW'(0) : acc_reg) + (step_neg ? -mul_p : mul_p);

    mi4_mul #(
        .DW (DW),
        .MW (MW),
        .BW (BW),
        .AW (DTW)
    ) u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (mul_ctrl),
        .a     (a_reg),
        .b     (b_opnd),
        .p     (mul_p),
        .done  (mul_done)
    );

    // divider operands: magnitudes of cofactor(j,i) scaled and determinant
    always_comb
    begin
        cof_sel  = cof_reg[{col_reg, row_reg}];
        cof_abs  = cof_sel[CFW-1] ? CFW'(-cof_sel) : CFW'(cof_sel);
        det_abs  = det_reg[DTW-1] ? DTW'(-det_reg) : DTW'(det_reg);
        div_num  = {cof_abs, {(2 * FRAC_BITS){1'b0}}};
        det_zero = (det_reg == '0);
    end

    mi4_div #(
        .DW  (DW),
        .NW  (NW),
        .DTW (DTW)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (det_abs),
        .q     (div_q),
        .done  (div_done)
    );

    // sign and saturation of the quotient
    always_comb
    begin
        res_neg = cof_sel[CFW-1] ^ det_reg[DTW-1];
        if (res_neg)
        begin
            res_sat = div_q[DW] | (div_q[DW-1] & (|div_q[DW-2:0]));
            res_val = res_sat ? $signed({1'b1, {(DW-1){1'b0}}}) : -$signed(div_q[DW-1:0]);
        end
        else
        begin
            res_sat = div_q[DW] | div_q[DW-1];
            res_val = res_sat ? $signed({1'b0, {(DW-1){1'b1}}}) : $signed(div_q[DW-1:0]);
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start && (rows_loaded_reg == LAST_POS))
                begin
                    state_next = ST_FETCH_A;
                end
            end
            ST_FETCH_A: state_next = ST_FETCH_B;
            ST_FETCH_B: state_next = ST_MUL;
            ST_MUL:
            begin
                if (mul_done)
                begin
                    state_next = (phase_reg == PH_DET && step_last) ? ST_ROW : ST_FETCH_A;
                end
            end
            ST_ROW:     state_next = det_zero ? ST_EMIT : ST_DIV_GO;
            ST_DIV_GO:  state_next = ST_DIV;
            ST_DIV:
            begin
                if (div_done)
                begin
                    state_next = (col_reg == LAST_POS) ? ST_EMIT : ST_DIV_GO;
                end
            end
            ST_EMIT:    state_next = (row_reg == LAST_POS) ? ST_IDLE : ST_ROW;
            default:    state_next = ST_IDLE;
        endcase
    end

    // state outputs
    always_comb
    begin
        busy           = (state_reg != ST_IDLE);
        valid          = (state_reg == ST_EMIT);
        mul_ctrl.start = (state_reg == ST_FETCH_B);
        mul_ctrl.kind  = b_kind;
        div_start      = (state_reg == ST_DIV_GO);
    end

    // sequencer counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            phase_reg       <= PH_COF;
            ci_reg          <= '0;
            s_reg           <= '0;
            row_reg         <= '0;
            col_reg         <= '0;
            rows_loaded_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (start)
                    begin
                        rows_loaded_reg <= rows_loaded_reg + 2'd1;
                        phase_reg       <= PH_COF;
                        ci_reg          <= '0;
                        s_reg           <= '0;
                        row_reg         <= '0;
                    end
                end
                ST_MUL:
                begin
                    if (mul_done)
                    begin
                        if (phase_reg == PH_COF && s_reg == LAST_COF_STEP)
                        begin
                            s_reg  <= '0;
                            ci_reg <= ci_reg + 4'd1;
                            if (ci_reg == LAST_COF_IDX)
                            begin
                                phase_reg <= PH_DET;
                            end
                        end
                        else
                        begin
                            s_reg <= s_reg + 4'd1;
                        end
                    end
                end
                ST_ROW:
                begin
                    col_reg <= '0;
                end
                ST_DIV:
                begin
                    if (div_done)
                    begin
                        col_reg <= col_reg + 2'd1;
                    end
                end
                ST_EMIT:
                begin
                    row_reg <= row_reg + 2'd1;
                end
                default:
                begin
                end
            endcase
        end
    end

    // matrix, minors, cofactors and results
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && start)
        begin
            mat_reg[rows_loaded_reg][0] <= elem0;
            mat_reg[rows_loaded_reg][1] <= elem1;
            mat_reg[rows_loaded_reg][2] <= elem2;
            mat_reg[rows_loaded_reg][3] <= elem3;
        end
        if (state_reg == ST_FETCH_A)
        begin
            a_reg <= mat_reg[a_row][a_col];
        end
        if (state_reg == ST_MUL && mul_done)
        begin
            acc_reg <= acc_new;
            if (step_last)
            begin
                if (phase_reg == PH_DET)
                begin
                    det_reg <= acc_new;
                end
                else if (st.b_minor)
                begin
                    cof_reg[ci_reg] <= acc_new[CFW-1:0];
                end
                else
                begin
                    minor_reg[st.m_idx] <= acc_new[MW-1:0];
                end
            end
        end
        if (state_reg == ST_ROW)
        begin
            sat_reg  <= 1'b0;
            sing_reg <= det_zero;
            if (det_zero)
            begin
                for (int k = 0; k < 4; k++)
                begin
                    inv_reg[k] <= '0;
                end
            end
        end
        if (state_reg == ST_DIV && div_done)
        begin
            inv_reg[col_reg] <= res_val;
            sat_reg          <= sat_reg | res_sat;
        end
    end

    assign inv0       = inv_reg[0];
    assign inv1       = inv_reg[1];
    assign inv2       = inv_reg[2];
    assign inv3       = inv_reg[3];
    assign row_number = row_reg;
    assign last_row   = (row_reg == LAST_POS);
    assign singular   = sing_reg;
    assign saturated  = sat_reg;

endmodule
`default_nettype wire

// ===== hw/rtl/mi4_chk.sv =====
`timescale 1ns / 1ps
`default_nettype none
// port checker for the 4x4 matrix inverse, bound to the top level
module mi4_chk #(
    parameter int DATA_WIDTH = 32
) (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         start,
    input logic                         busy,
    input logic                         valid,
    input logic signed [DATA_WIDTH-1:0] inv0,
    input logic signed [DATA_WIDTH-1:0] inv1,
    input logic signed [DATA_WIDTH-1:0] inv2,
    input logic signed [DATA_WIDTH-1:0] inv3,
    input logic [1:0]                   row_number,
    input logic                         last_row,
    input logic                         singular,
    input logic                         saturated
);
    // results only come out while a matrix is in work
    a_valid_busy: assert property (@(posedge clk) disable iff (!rst_n)
        valid |-> busy)
        else $error("result transfer while idle");

    // last row is row three and ends the work
    a_last_done: assert property (@(posedge clk) disable iff (!rst_n)
        valid && last_row |-> row_number == 2'd3 ##1 !busy)
        else $error("last row misplaced or block stays busy");

    // rows are numbered in order
    a_row_order: assert property (@(posedge clk) disable iff (!rst_n)
        valid && !last_row |=> !valid ##1 (!valid || row_number == $past(row_number, 2) + 2'd1))
        else $error("result rows out of order");

    // singular matrix gives zero rows, never clamped
    a_singular_zero: assert property (@(posedge clk) disable iff (!rst_n)
        valid && singular |-> inv0 == '0 && inv1 == '0 && inv2 == '0 && inv3 == '0
            && !saturated)
        else $error("singular row not zero");

    // a start while busy does not end the work before a result row
    a_start_ignored: assert property (@(posedge clk) disable iff (!rst_n)
        busy && start && !valid |=> busy)
        else $error("busy dropped unexpectedly");

endmodule

bind matrix_inverse_4x4 mi4_chk #(.DATA_WIDTH(DATA_WIDTH)) u_mi4_chk (.*);
`default_nettype wire
